FILE: rtl/core/percentile_contrast_stretch_assert.svh
// Assertion macros for the percentile contrast stretch block.
// Used by percentile_contrast_stretch.sv; expects clk and rst_n in scope.
`ifndef PERCENTILE_CONTRAST_STRETCH_ASSERT_SVH
`define PERCENTILE_CONTRAST_STRETCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pcs_pkg.sv
// Shared types and constants of the percentile contrast stretch block.
// No dependencies; imported by percentile_contrast_stretch.
package pcs_pkg;

  // Register and field widths.
  localparam int CLIP_W = 14;
  localparam int PIX_W  = 8;
  localparam int STR_W  = 16;

  // Default frame capacity.
  localparam int MAX_PIXELS_DEF = 65536;

  // Register reset values.
  localparam logic [CLIP_W-1:0] CLIP_LOW_RST  = 14'd100;
  localparam logic [CLIP_W-1:0] CLIP_HIGH_RST = 14'd9900;

  // Percentile scale: clip values are in hundredths of a percent.
  localparam logic [CLIP_W-1:0] CLIP_SCALE = 14'd10000;

  // BGR to gray weights in Q14 and the rounding term.
  localparam logic [CLIP_W-1:0] GRAY_COEF_B = 14'd1868;
  localparam logic [CLIP_W-1:0] GRAY_COEF_G = 14'd9617;
  localparam logic [CLIP_W-1:0] GRAY_COEF_R = 14'd4899;
  localparam logic [CLIP_W-1:0] GRAY_ROUND  = 14'd8192;

  // Input operation codes carried on tuser.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CLIP_LOW  = 2'd0,
    CFG_CLIP_HIGH = 2'd1,
    CFG_THREE_CH  = 2'd2
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRAY1,
    ST_GRAY2,
    ST_HRD,
    ST_HWR,
    ST_PMUL,
    ST_SCAN,
    ST_SCH,
    ST_SDIV,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/core/percentile_contrast_stretch.sv
// Percentile contrast stretch: frame store, gray histogram, percentile search
// and readout stretch around one shared multiplier and one shared divider.
// Depends on pcs_pkg and percentile_contrast_stretch_assert.svh.
//
// Usage: input beats on in_* carry a load (tuser low) or a readout request
// (tuser high). A load beat stores one pixel and adds its gray value to the
// histogram while the store has room; tlast on a load closes the frame and
// starts the percentile search. A readout beat on a finished frame with
// pixels left returns the next stored pixel, stretched, on out_*.
// Configuration writes on cfg_* are taken in any cycle. The closing load
// forms the count-times-clip products, then one pass over the 256 bins
// compares the running count, scaled by 10000, against them. A readout
// stretches each channel, by the 16-step shared divider unless it clamps;
// in_tready stays low while a beat is worked on. Reset clears the control
// registers, the histogram and the frame flag; the frame store is not
// cleared. A result waits in the output register while out_tready is low;
// the next load is still taken, and a readout holds until it is free.
module percentile_contrast_stretch #(
  parameter int MAX_PIXELS = pcs_pkg::MAX_PIXELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input beats.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,   // chan_b [7:0], chan_g [15:8], chan_r [23:16]
  input  logic                      in_tuser,   // func
  input  logic                      in_tlast,   // last_pixel
  // Result beats.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,  // out_b [7:0], out_g [15:8], out_r [23:16]
  output logic                      out_tlast,  // last_out
  // Configuration writes.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  pcs_pkg::cfg_idx_t         cfg_index,
  input  logic [pcs_pkg::CLIP_W-1:0] cfg_data
);
  import pcs_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int AW     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int MA_W   = (CNT_W > PIX_W) ? CNT_W : PIX_W;
  localparam int PROD_W = MA_W + CLIP_W;
  localparam int DCW    = $clog2(PROD_W + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

  // Control registers.
  state_t              state_r, state_nxt;
  logic [CLIP_W-1:0]   clip_low_r, clip_low_nxt;
  logic [CLIP_W-1:0]   clip_high_r, clip_high_nxt;
  logic                three_ch_r, three_ch_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    rp_r, rp_nxt;
  logic                frame_ready_r, frame_ready_nxt;
  logic [PIX_W-1:0]    lo_r, lo_nxt;
  logic [PIX_W-1:0]    hi_r, hi_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                sel_hi_r, sel_hi_nxt;
  logic [8:0]          scan_cnt_r, scan_cnt_nxt;
  logic [DCW-1:0]      dcnt_r, dcnt_nxt;
  logic [1:0]          ch_r, ch_nxt;
  logic                mode_r, mode_nxt;
  logic                last_r, last_nxt;
  logic [255:0]        hist_vld_r;

  // Payload registers.
  logic [23:0]           pix_r, pix_nxt;
  logic [PROD_W-1:0]     acc_r, acc_nxt;
  logic [PROD_W-1:0]     div_q_r, div_q_nxt;
  logic [CLIP_W-1:0]     div_rem_r, div_rem_nxt;
  logic [CLIP_W-1:0]     div_den_r, div_den_nxt;
  logic [PROD_W-1:0]     idx_lo_r, idx_lo_nxt;
  logic [PROD_W-1:0]     idx_hi_r, idx_hi_nxt;
  logic [CNT_W-1:0]      cum_r, cum_nxt;
  logic [PROD_W-1:0]     csum_r, csum_nxt;
  logic                  lo_found_r, lo_found_nxt;
  logic                  hi_found_r, hi_found_nxt;
  logic [2:0][PIX_W-1:0] res_r, res_nxt;
  logic [23:0]           out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  // Memories.
  logic [23:0]      frame_store [MAX_PIXELS];
  logic [CNT_W-1:0] hist_mem [256];
  logic [23:0]      store_q_r;
  logic [CNT_W-1:0] hist_q_r;
  logic             hist_qv_r;

  // Memory controls.
  logic             store_we;
  logic [AW-1:0]    store_waddr;
  logic             hist_we;
  logic [7:0]       hist_raddr;
  logic [CNT_W-1:0] hist_wdata;
  logic             hist_clr;

  // Shared multiplier.
  logic [MA_W-1:0]   mul_a;
  logic [CLIP_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;

  // Shared divider step.
  logic [CLIP_W:0]   div_t;
  logic [CLIP_W:0]   div_diff;
  logic              div_ge;

  // Working values.
  logic [CNT_W-1:0]  cnt_base;
  logic [CNT_W-1:0]  bin_val;
  logic [8:0]        scan_prev;
  logic [PIX_W-1:0]  x_val;
  logic [PIX_W-1:0]  den_val;
  logic [STR_W-1:0]  num_val;
  logic [CLIP_W:0]   rem_x2;
  logic [8:0]        q_round;
  logic              round_up;
  logic              res_wr;
  logic [PIX_W-1:0]  res_val;
  logic [CNT_W-1:0]  rp_inc;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign mul_p = {{CLIP_W{1'b0}}, mul_a} * {{MA_W{1'b0}}, mul_b};

  // One restoring division step: shift in the next dividend bit.
  assign div_t    = {div_rem_r, div_q_r[PROD_W-1]};
  assign div_ge   = (div_t >= {1'b0, div_den_r});
  assign div_diff = div_t - {1'b0, div_den_r};

  assign scan_prev = scan_cnt_r - 9'd1;
  assign bin_val   = hist_qv_r ? hist_q_r : '0;
  assign rp_inc    = rp_r + 1'b1;

  // Readout channel and its stretch operands.
  always_comb begin
    case (ch_r)
      2'd1:    x_val = store_q_r[15:8];
      2'd2:    x_val = store_q_r[23:16];
      default: x_val = store_q_r[7:0];
    endcase
    den_val  = hi_r - lo_r;
    num_val  = {x_val - lo_r, 8'd0} - {8'd0, x_val - lo_r};
    rem_x2   = {div_rem_r, 1'b0};
    round_up = (rem_x2 > {1'b0, div_den_r}) ||
               ((rem_x2 == {1'b0, div_den_r}) && div_q_r[0]);
    q_round  = div_q_r[8:0] + {8'd0, round_up};
  end

  // Sequencer: next state, datapath and memory controls.
  always_comb begin
    state_nxt       = state_r;
    clip_low_nxt    = clip_low_r;
    clip_high_nxt   = clip_high_r;
    three_ch_nxt    = three_ch_r;
    count_nxt       = count_r;
    rp_nxt          = rp_r;
    frame_ready_nxt = frame_ready_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    out_valid_nxt   = out_valid_r;
    sel_hi_nxt      = sel_hi_r;
    scan_cnt_nxt    = scan_cnt_r;
    dcnt_nxt        = dcnt_r;
    ch_nxt          = ch_r;
    mode_nxt        = mode_r;
    last_nxt        = last_r;
    pix_nxt         = pix_r;
    acc_nxt         = acc_r;
    div_q_nxt       = div_q_r;
    div_rem_nxt     = div_rem_r;
    div_den_nxt     = div_den_r;
    idx_lo_nxt      = idx_lo_r;
    idx_hi_nxt      = idx_hi_r;
    cum_nxt         = cum_r;
    csum_nxt        = csum_r;
    lo_found_nxt    = lo_found_r;
    hi_found_nxt    = hi_found_r;
    res_nxt         = res_r;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;
    store_we        = 1'b0;
    store_waddr     = '0;
    hist_we         = 1'b0;
    hist_raddr      = acc_r[CLIP_W+7:CLIP_W];
    hist_wdata      = bin_val + 1'b1;
    hist_clr        = 1'b0;
    mul_a           = MA_W'(count_r);
    mul_b           = sel_hi_r ? clip_high_r : clip_low_r;
    cnt_base        = frame_ready_r ? '0 : count_r;
    res_wr          = 1'b0;
    res_val         = '0;

    // Configuration writes.
    if (cfg_valid) begin
      case (cfg_index)
        CFG_CLIP_LOW:  clip_low_nxt  = cfg_data;
        CFG_CLIP_HIGH: clip_high_nxt = cfg_data;
        CFG_THREE_CH:  three_ch_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    // The output register frees when its beat is taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        mul_a = MA_W'(in_tdata[7:0]);
        mul_b = GRAY_COEF_B;
        if (in_tvalid) begin
          if (in_tuser == FUNC_LOAD) begin
            pix_nxt  = in_tdata;
            last_nxt = in_tlast;
            // A load after a finished frame starts a new one.
            if (frame_ready_r) begin
              frame_ready_nxt = 1'b0;
              rp_nxt          = '0;
              hist_clr        = 1'b1;
            end
            if (cnt_base < MAX_CNT) begin
              store_we    = 1'b1;
              store_waddr = cnt_base[AW-1:0];
              count_nxt   = cnt_base + 1'b1;
              if (three_ch_r) begin
                acc_nxt   = mul_p + PROD_W'(GRAY_ROUND);
                state_nxt = ST_GRAY1;
              end else begin
                acc_nxt   = PROD_W'({in_tdata[7:0], {CLIP_W{1'b0}}});
                state_nxt = ST_HRD;
              end
            end else begin
              count_nxt = cnt_base;
              state_nxt = in_tlast ? ST_PMUL : ST_IDLE;
            end
          end else if (frame_ready_r && (rp_r < count_r)) begin
            ch_nxt    = 2'd0;
            mode_nxt  = three_ch_r;
            state_nxt = ST_SCH;
          end
        end
      end

      // Gray accumulation, one weighted channel a cycle.
      ST_GRAY1: begin
        mul_a     = MA_W'(pix_r[15:8]);
        mul_b     = GRAY_COEF_G;
        acc_nxt   = acc_r + mul_p;
        state_nxt = ST_GRAY2;
      end

      ST_GRAY2: begin
        mul_a     = MA_W'(pix_r[23:16]);
        mul_b     = GRAY_COEF_R;
        acc_nxt   = acc_r + mul_p;
        state_nxt = ST_HRD;
      end

      // Histogram read-modify-write.
      ST_HRD: begin
        state_nxt = ST_HWR;
      end

      ST_HWR: begin
        hist_we   = 1'b1;
        state_nxt = last_r ? ST_PMUL : ST_IDLE;
      end

      // Percentile products: count times clip, low level first.
      ST_PMUL: begin
        if (sel_hi_r) begin
          idx_hi_nxt   = mul_p;
          sel_hi_nxt   = 1'b0;
          scan_cnt_nxt = '0;
          cum_nxt      = '0;
          csum_nxt     = '0;
          lo_found_nxt = 1'b0;
          hi_found_nxt = 1'b0;
          state_nxt    = ST_SCAN;
        end else begin
          idx_lo_nxt = mul_p;
          sel_hi_nxt = 1'b1;
        end
      end

      // Cumulative pass over the bins, one bin a cycle, each from the registered read of the step before.
      // The running count passes floor(count*clip/10000) exactly when
      // 10000 times it exceeds count*clip; reaching the full count stands
      // in for the clamp to the last pixel.
      ST_SCAN: begin
        hist_raddr = scan_cnt_r[7:0];
        mul_a      = MA_W'(bin_val);
        mul_b      = CLIP_SCALE;
        if (scan_cnt_r != '0) begin
          cum_nxt  = cum_r + bin_val;
          csum_nxt = csum_r + mul_p;
          if (!lo_found_r && ((csum_nxt > idx_lo_r) || (cum_nxt >= count_r))) begin
            lo_nxt       = scan_prev[7:0];
            lo_found_nxt = 1'b1;
          end
          if (!hi_found_r && ((csum_nxt > idx_hi_r) || (cum_nxt >= count_r))) begin
            hi_nxt       = scan_prev[7:0];
            hi_found_nxt = 1'b1;
          end
        end
        if (scan_cnt_r[8]) begin
          if (!lo_found_nxt) lo_nxt = '1;
          if (!hi_found_nxt) hi_nxt = '1;
          if (count_r == '0) begin
            lo_nxt = '0;
            hi_nxt = '0;
          end
          frame_ready_nxt = 1'b1;
          rp_nxt          = '0;
          state_nxt       = ST_IDLE;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end

      // Stretch one channel: clamp cases directly, the rest by division.
      ST_SCH: begin
        if (hi_r <= lo_r) begin
          res_wr  = 1'b1;
          res_val = x_val;
        end else if (x_val <= lo_r) begin
          res_wr  = 1'b1;
          res_val = '0;
        end else if (x_val >= hi_r) begin
          res_wr  = 1'b1;
          res_val = '1;
        end else begin
          div_q_nxt   = {num_val, {(PROD_W-STR_W){1'b0}}};
          div_rem_nxt = '0;
          div_den_nxt = CLIP_W'(den_val);
          dcnt_nxt    = DCW'(STR_W);
          state_nxt   = ST_SDIV;
        end
      end

      ST_SDIV: begin
        if (dcnt_r != '0) begin
          div_q_nxt   = {div_q_r[PROD_W-2:0], div_ge};
          div_rem_nxt = div_ge ? div_diff[CLIP_W-1:0] : div_t[CLIP_W-1:0];
          dcnt_nxt    = dcnt_r - 1'b1;
        end else begin
          res_wr  = 1'b1;
          res_val = q_round[8] ? '1 : q_round[7:0];
        end
      end

      // Hand the pixel to the output register once it is free.
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {mode_r ? res_r[2] : 8'd0,
                           mode_r ? res_r[1] : 8'd0,
                           res_r[0]};
          out_last_nxt  = (rp_inc == count_r);
          out_valid_nxt = 1'b1;
          rp_nxt        = rp_inc;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Store a channel result and move to the next channel or the output.
    if (res_wr) begin
      res_nxt[ch_r] = res_val;
      if (ch_r == (mode_r ? 2'd2 : 2'd0)) begin
        state_nxt = ST_OUT;
      end else begin
        ch_nxt    = ch_r + 1'b1;
        state_nxt = ST_SCH;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      clip_low_r    <= CLIP_LOW_RST;
      clip_high_r   <= CLIP_HIGH_RST;
      three_ch_r    <= 1'b0;
      count_r       <= '0;
      rp_r          <= '0;
      frame_ready_r <= 1'b0;
      lo_r          <= '0;
      hi_r          <= '0;
      out_valid_r   <= 1'b0;
      sel_hi_r      <= 1'b0;
      scan_cnt_r    <= '0;
      dcnt_r        <= '0;
      ch_r          <= '0;
      mode_r        <= 1'b0;
      last_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clip_low_r    <= clip_low_nxt;
      clip_high_r   <= clip_high_nxt;
      three_ch_r    <= three_ch_nxt;
      count_r       <= count_nxt;
      rp_r          <= rp_nxt;
      frame_ready_r <= frame_ready_nxt;
      lo_r          <= lo_nxt;
      hi_r          <= hi_nxt;
      out_valid_r   <= out_valid_nxt;
      sel_hi_r      <= sel_hi_nxt;
      scan_cnt_r    <= scan_cnt_nxt;
      dcnt_r        <= dcnt_nxt;
      ch_r          <= ch_nxt;
      mode_r        <= mode_nxt;
      last_r        <= last_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    acc_r      <= acc_nxt;
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    div_den_r  <= div_den_nxt;
    idx_lo_r   <= idx_lo_nxt;
    idx_hi_r   <= idx_hi_nxt;
    cum_r      <= cum_nxt;
    csum_r     <= csum_nxt;
    lo_found_r <= lo_found_nxt;
    hi_found_r <= hi_found_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // Histogram bin valid bits: a bin that is not valid reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (hist_clr) begin
      hist_vld_r <= '0;
    end else if (hist_we) begin
      hist_vld_r[acc_r[CLIP_W+7:CLIP_W]] <= 1'b1;
    end
  end

  // Histogram memory, registered read.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[acc_r[CLIP_W+7:CLIP_W]] <= hist_wdata;
    end
    hist_q_r  <= hist_mem[hist_raddr];
    hist_qv_r <= hist_vld_r[hist_raddr];
  end

  // Frame store, registered read at the read pointer.
  always_ff @(posedge clk) begin
    if (store_we) begin
      frame_store[store_waddr] <= in_tdata;
    end
    store_q_r <= frame_store[rp_r[AW-1:0]];
  end

  `include "percentile_contrast_stretch_assert.svh"

  `PCS_ASSERT_SAME(a_count_bound, 1'b1, count_r <= MAX_CNT, "pixel count beyond capacity")
  `PCS_ASSERT_SAME(a_rp_bound, frame_ready_r, rp_r <= count_r, "read pointer past frame end")
  `PCS_ASSERT_SAME(a_out_from_seq, $rose(out_valid_r), $past(state_r == ST_OUT), "result beat not from output step")
  `PCS_ASSERT_NEXT(a_scan_done, (state_r == ST_SCAN) && scan_cnt_r[8], frame_ready_r && (state_r == ST_IDLE), "scan end did not close frame")

endmodule

FILE: tb/sv/tb_percentile_contrast_stretch.sv
// Self-checking testbench for the percentile contrast stretch block.
// Depends on pcs_pkg and percentile_contrast_stretch; drives frames of loads and readouts.
`default_nettype none
module tb_percentile_contrast_stretch;
  timeunit 1ns;
  timeprecision 1ps;
  import pcs_pkg::*;

  localparam int NPIX = 65536;

  typedef struct packed {
    logic       last;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_CLIP_LOW;
  logic [CLIP_W-1:0] cfg_data = '0;

  percentile_contrast_stretch uut (.*);

  initial forever #6 clk = ~clk;

  // Predictor state.
  logic [13:0] clip_lo_q, clip_hi_q;
  logic        bgr_mode;
  logic [23:0] pix_mem [int];
  int unsigned hist [256];
  int unsigned n_pix, rd_ptr;
  logic [7:0]  lvl_lo, lvl_hi;
  logic        have_frame;

  pixel_out_t stretched_q[$];
  int errors = 0, results_seen = 0, loads_sent = 0, reads_sent = 0;
  bit stall_mode = 0;

  task automatic report(string what);
    errors++;
    $display("ERROR %0t: %s", $time, what);
  endtask

  function automatic logic [7:0] percentile_level(logic [13:0] clip);
    longint idx, cum;
    cum = 0;
    if (n_pix == 0) return 8'd0;
    idx = (longint'(n_pix) * clip) / 10000;
    if (idx > n_pix - 1) idx = n_pix - 1;
    for (int v = 0; v < 256; v++) begin
      cum += hist[v];
      if (cum > idx) return v[7:0];
    end
    return 8'd255;
  endfunction

  function automatic logic [7:0] stretch_chan(logic [7:0] x);
    int unsigned num, den, q, rm;
    if (lvl_hi <= lvl_lo) return x;
    if (x <= lvl_lo) return 8'd0;
    if (x >= lvl_hi) return 8'd255;
    num = 255 * (x - lvl_lo);
    den = lvl_hi - lvl_lo;
    q = num / den;
    rm = num % den;
    if (2 * rm > den || (2 * rm == den && q[0])) q++;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Advance the predictor by one accepted input beat.
  function automatic void predict_beat(logic func, logic [23:0] d, logic last);
    int unsigned gray;
    pixel_out_t o;
    if (func == FUNC_LOAD) begin
      if (have_frame) begin
        foreach (hist[i]) hist[i] = 0;
        n_pix = 0; rd_ptr = 0; have_frame = 0;
      end
      if (n_pix < NPIX) begin
        gray = bgr_mode ? (1868 * d[7:0] + 9617 * d[15:8] + 4899 * d[23:16] + 8192) >> 14
                        : d[7:0];
        if (gray > 255) gray = 255;
        pix_mem[n_pix] = d;
        hist[gray]++;
        n_pix++;
      end
      if (last) begin
        lvl_lo = percentile_level(clip_lo_q);
        lvl_hi = percentile_level(clip_hi_q);
        rd_ptr = 0; have_frame = 1;
      end
    end else if (have_frame && rd_ptr < n_pix) begin
      o.b = stretch_chan(pix_mem[rd_ptr][7:0]);
      o.g = bgr_mode ? stretch_chan(pix_mem[rd_ptr][15:8]) : 8'd0;
      o.r = bgr_mode ? stretch_chan(pix_mem[rd_ptr][23:16]) : 8'd0;
      o.last = (rd_ptr + 1 == n_pix);
      rd_ptr++;
      stretched_q = {stretched_q, o};
    end
  endfunction

  task automatic wait_drained();
    while (stretched_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [13:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CLIP_LOW:  clip_lo_q = val;
      CFG_CLIP_HIGH: clip_hi_q = val;
      default:       bgr_mode = val[0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender burst/gap shaping.
  int burst_left = 0;

  task automatic send_beat(logic func, logic [23:0] d, logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1; in_tuser <= func; in_tdata <= d; in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    predict_beat(func, d, last);
    if (func == FUNC_LOAD) loads_sent++; else reads_sent++;
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic send_frame(int n, int kind);
    logic [23:0] d;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: d = 24'($urandom);
        1: d = {8'($urandom_range(90, 110)), 8'($urandom_range(60, 160)),
                8'($urandom_range(50, 200))};
        default: d = {3{8'($urandom_range(0, 1) ? 255 : 0)}};
      endcase
      send_beat(FUNC_LOAD, d, i == n - 1);
    end
  endtask

  task automatic read_frame(int n);
    for (int i = 0; i < n; i++)
      send_beat(FUNC_READ, 24'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Result checker.
  always @(posedge clk) begin
    pixel_out_t exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (stretched_q.size() == 0) report("result beat with nothing expected");
      else begin
        exp_px = stretched_q.pop_front();
        if (out_tdata[7:0] !== exp_px.b)
          report($sformatf("out_b got %0d want %0d", out_tdata[7:0], exp_px.b));
        if (out_tdata[15:8] !== exp_px.g)
          report($sformatf("out_g got %0d want %0d", out_tdata[15:8], exp_px.g));
        if (out_tdata[23:16] !== exp_px.r)
          report($sformatf("out_r got %0d want %0d", out_tdata[23:16], exp_px.r));
        if (out_tlast !== exp_px.last)
          report($sformatf("last_out got %0b want %0b", out_tlast, exp_px.last));
      end
    end
  end

  // Receiver stall pattern; stall_mode 0 keeps it always ready.
  int stall_cnt = 0;
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    out_tready <= !stall_mode || (stall_cnt % 7 < 4) || ($urandom_range(0, 3) == 0);
  end

  task automatic test_directed();
    // Readout before any frame, then extremes in gray mode.
    send_beat(FUNC_READ, '0, 1'b0);
    send_beat(FUNC_LOAD, 24'hFFFFFF, 1'b0);
    send_beat(FUNC_LOAD, 24'h000000, 1'b0);
    send_beat(FUNC_LOAD, 24'h000080, 1'b0);
    send_beat(FUNC_LOAD, 24'hAA5540, 1'b1);
    read_frame(5);   // one past the end
    // Flat frame: one pixel, levels equal.
    send_beat(FUNC_LOAD, 24'h123456, 1'b1);
    read_frame(2);
    wait_drained();
    write_reg(CFG_THREE_CH, 14'd1);
    send_beat(FUNC_LOAD, 24'hFF00FF, 1'b0);
    send_beat(FUNC_LOAD, 24'h00FF00, 1'b0);
    send_beat(FUNC_LOAD, 24'hFFFFFF, 1'b0);
    send_beat(FUNC_LOAD, 24'h808080, 1'b1);
    read_frame(2);
    // Mode change between load and readout.
    wait_drained();
    write_reg(CFG_THREE_CH, 14'd0);
    read_frame(3);
    wait_drained();
  endtask

  task automatic test_clip_settings();
    logic [13:0] lo_set[5] = '{14'd0, 14'd0, 14'd2500, 14'd10000, 14'h3FFF};
    logic [13:0] hi_set[5] = '{14'd10000, 14'h3FFF, 14'd7500, 14'd0, 14'd5000};
    for (int s = 0; s < 5; s++) begin
      write_reg(CFG_CLIP_LOW, lo_set[s]);
      write_reg(CFG_CLIP_HIGH, hi_set[s]);
      write_reg(CFG_THREE_CH, 14'(s[0]));
      send_frame($urandom_range(3, 20), $urandom_range(0, 2));
      read_frame(n_pix);
      wait_drained();
    end
  endtask

  task automatic test_random_frames();
    int n;
    stall_mode = 1;
    while (loads_sent + reads_sent < 1800) begin
      if ($urandom_range(0, 4) == 0) begin
        wait_drained();
        write_reg(CFG_CLIP_LOW, 14'($urandom_range(0, 3000)));
        write_reg(CFG_CLIP_HIGH, $urandom_range(0, 5) == 0 ? 14'($urandom)
                                                        : 14'($urandom_range(7000, 10000)));
        write_reg(CFG_THREE_CH, 14'($urandom_range(0, 1)));
      end
      n = $urandom_range(1, 40);
      send_frame(n, $urandom_range(0, 2));
      // Mostly full readouts, sometimes partial or overrun.
      read_frame($urandom_range(0, 5) == 0 ? $urandom_range(0, n + 3) : n);
      if ($urandom_range(0, 9) == 0) stall_mode = !stall_mode;
    end
    // Pause until everything is back.
    wait_drained();
  endtask

  initial begin
    clip_lo_q = CLIP_LOW_RST; clip_hi_q = CLIP_HIGH_RST; bgr_mode = 0;
    foreach (hist[i]) hist[i] = 0;
    n_pix = 0; rd_ptr = 0; lvl_lo = 0; lvl_hi = 0; have_frame = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_clip_settings();
    test_random_frames();
    wait_drained();
    if (stretched_q.size() != 0) report("expected results left over");
    $display("Covered %0d loads and %0d readouts, %0d stretched pixels checked.",
             loads_sent, reads_sent, results_seen);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout waiting for results.");
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/pcs_pkg.sv
rtl/core/percentile_contrast_stretch.sv
tb/sv/tb_percentile_contrast_stretch.sv
